### hdl/mhpq_pkg.sv
// shared constants, types and helpers of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

    // heap geometry
    localparam int HEAP_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = 11;
    localparam int DATA_W     = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [CNT_W:0]           wide_pos_t;

    // request opcodes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    // one-based heap position to zero-based memory address
    function automatic addr_t pos_addr(input wide_pos_t pos);
        wide_pos_t idx;
        idx = pos - wide_pos_t'(1);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

### hdl/mhpq_if.sv
// request and response channel interfaces of the max-heap priority queue
`timescale 1ns / 1ps

interface mhpq_in_if
    import mhpq_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  opcode;
    data_t value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mhpq_out_if
    import mhpq_pkg::*;
();
    logic       valid;
    logic       ready;
    data_t      removed_value;
    data_t      top_value;
    count_t     entry_count;
    logic [1:0] status;

    modport source (output valid, output removed_value, output top_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input removed_value, input top_value,
                    input entry_count, input status, output ready);
endinterface

### hdl/mhpq_ram.sv
// heap storage: one write port, two registered read ports
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [DATA_W-1:0] rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_b
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, data registered and valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/max_heap_priority_queue_unit.sv
// top level of the max-heap priority queue: sequencer, counters and storage
//
// channel    dir  payload                                          transfer
// request    in   opcode, value                                    valid & ready
// response   out  removed_value, top_value, entry_count, status    valid & ready
//
// insert sifts up and remove sifts down, with one memory read and one compare per level
// moved, and reaching the root ends a sift-up without a compare; a dropped insert, an
// empty remove or a first entry skips the sift, and removing the last entry reads it
// but does not sift
// reset clears the fill count and handshake state; the storage needs no clearing
// a result waits in the output register while the next runs; a second one stalls in S_DONE
`timescale 1ns / 1ps

module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mhpq_in_if.sink           request,
    mhpq_out_if.source        response
);

    state_t  state_reg, state_next;
    count_t  cnt_reg, cnt_next;
    count_t  pos_reg, pos_next;
    data_t   cur_reg, cur_next;
    data_t   root_reg, root_next;
    data_t   removed_reg, removed_next;
    status_t status_reg, status_next;

    logic    out_valid_reg, out_valid_next;
    data_t   out_removed_reg;
    data_t   out_top_reg;
    count_t  out_count_reg;
    status_t out_status_reg;

    logic      ram_we;
    count_t    ram_wpos;
    data_t     ram_wdata;
    addr_t     raddr_a, raddr_b;
    data_t     rdata_a, rdata_b;

    logic      in_xfer, rsp_load;
    count_t    ins_pos, parent_pos;
    wide_pos_t left_pos, right_pos, child_pos;
    logic      right_ok, pick_right, up_move, dn_move;
    data_t     child_val;

    // heap storage
    mhpq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (pos_addr({1'b0, ram_wpos})),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // handshakes
    assign request.ready = (state_reg == S_IDLE);
    assign in_xfer       = request.valid && request.ready;
    assign rsp_load      = (state_reg == S_DONE) && (!out_valid_reg || response.ready);

    // position arithmetic and compares
    assign ins_pos    = cnt_reg + count_t'(1);
    assign parent_pos = pos_reg >> 1;
    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = left_pos + wide_pos_t'(1);
    assign right_ok   = right_pos <= {1'b0, cnt_reg};
    assign pick_right = right_ok && (rdata_b > rdata_a);
    assign child_val  = pick_right ? rdata_b : rdata_a;
    assign child_pos  = pick_right ? right_pos : left_pos;
    assign up_move    = cur_reg > rdata_a;
    assign dn_move    = child_val > cur_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (request.opcode == OP_INSERT)
                    begin
                        if (cnt_reg == count_t'(HEAP_DEPTH) || cnt_reg == '0)
                            state_next = S_DONE;
                        else
                            state_next = S_UP_CMP;
                    end
                    else
                    begin
                        state_next = (cnt_reg == '0) ? S_DONE : S_LAST_RD;
                    end
                end
            end
            S_LAST_RD: state_next = (cnt_reg == '0) ? S_DONE : S_DN_RD;
            S_UP_RD:   state_next = (pos_reg == count_t'(1)) ? S_DONE : S_UP_CMP;
            S_UP_CMP:  state_next = up_move ? S_UP_RD : S_DONE;
            S_DN_RD:   state_next = (left_pos > {1'b0, cnt_reg}) ? S_DONE : S_DN_CMP;
            S_DN_CMP:  state_next = dn_move ? S_DN_RD : S_DONE;
            S_DONE:    state_next = rsp_load ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        root_next    = root_reg;
        ram_we       = 1'b0;
        ram_wpos     = pos_reg;
        ram_wdata    = cur_reg;
        raddr_a      = '0;
        raddr_b      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    removed_next = '0;
                    status_next  = ST_OK;
                    if (request.opcode == OP_INSERT)
                    begin
                        if (cnt_reg == count_t'(HEAP_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cnt_next = ins_pos;
                            pos_next = ins_pos;
                            cur_next = request.value;
                            if (cnt_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_wpos  = count_t'(1);
                                ram_wdata = request.value;
                            end
                            else
                            begin
                                raddr_a = pos_addr({1'b0, ins_pos >> 1});
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            removed_next = root_reg;
                            raddr_a      = pos_addr({1'b0, cnt_reg});
                            cnt_next     = cnt_reg - count_t'(1);
                        end
                    end
                end
            end
            // last entry arrives and becomes the value to sift down
            S_LAST_RD:
            begin
                cur_next = rdata_a;
                pos_next = count_t'(1);
            end
            S_UP_RD:
            begin
                if (pos_reg == count_t'(1))
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    raddr_a = pos_addr({1'b0, parent_pos});
                end
            end
            // parent moves down into the hole, or the value settles
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (up_move)
                begin
                    ram_wdata = rdata_a;
                    pos_next  = parent_pos;
                end
            end
            S_DN_RD:
            begin
                if (left_pos > {1'b0, cnt_reg})
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    raddr_a = pos_addr(left_pos);
                    raddr_b = pos_addr(right_pos);
                end
            end
            // larger child moves up into the hole, or the value settles
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (dn_move)
                begin
                    ram_wdata = child_val;
                    pos_next  = child_pos[CNT_W-1:0];
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        // root mirror follows every write to the first position
        if (ram_we && ram_wpos == count_t'(1))
        begin
            root_next = ram_wdata;
        end
    end

    // output register next valid
    always_comb
    begin
        if (rsp_load)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        root_reg    <= root_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_removed_reg <= removed_reg;
            out_top_reg     <= (cnt_reg != '0) ? root_reg : data_t'(0);
            out_count_reg   <= cnt_reg;
            out_status_reg  <= status_reg;
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.removed_value = out_removed_reg;
    assign response.top_value     = out_top_reg;
    assign response.entry_count   = out_count_reg;
    assign response.status        = out_status_reg;

    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= count_t'(HEAP_DEPTH))
        else $error("fill count above heap depth");

    // an accepted item moves the fill count by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (cnt_reg == $past(cnt_reg) ||
                     cnt_reg == $past(cnt_reg) + count_t'(1) ||
                     cnt_reg == $past(cnt_reg) - count_t'(1)))
        else $error("fill count jumped");

    // storage writes stay inside the filled part of the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wpos != '0 && ram_wpos <= cnt_next))
        else $error("heap write outside filled range");

    // a dropped insert is only reported on a full heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.status == ST_FULL) |->
            response.entry_count == count_t'(HEAP_DEPTH))
        else $error("full status with room left");

endmodule

### tb/tb_top.sv
// self-checking testbench of the max-heap priority queue with a shadow heap predictor
`timescale 1ns / 1ps

module tb_top;
    import mhpq_pkg::*;

    typedef struct {
        op_t   op;
        data_t value;
    } heap_req_t;

    typedef struct {
        data_t   removed;
        data_t   top;
        count_t  count;
        status_t status;
    } heap_result_t;

    logic clk;
    logic rst_n;

    mhpq_in_if  req_if();
    mhpq_out_if rsp_if();

    max_heap_priority_queue_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    // shadow copy of the heap, one-indexed like the block
    data_t shadow_heap [1:HEAP_DEPTH];
    int    shadow_fill;

    heap_req_t    pending_reqs [$];
    heap_result_t expected_results [$];
    heap_req_t    next_req;
    heap_result_t due;
    int           gen_fill;
    int           accepted_reqs;
    int           checked_results;
    int           fail_count;
    int           full_drops;
    int           empty_removes;
    int           peak_fill;
    int           hold_left;
    bit           hold_done;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one request to the shadow heap and return what the block must report
    function automatic heap_result_t heap_apply(op_t op, data_t value);
        heap_result_t res;
        int           pos;
        int           par;
        int           lch;
        int           rch;
        int           best;
        data_t        tmp;
        res.removed = '0;
        res.status  = ST_OK;
        if (op == OP_INSERT) begin
            if (shadow_fill >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                shadow_fill++;
                shadow_heap[shadow_fill] = value;
                // sift up while strictly larger than the parent
                pos = shadow_fill;
                while (pos > 1) begin
                    par = pos / 2;
                    if (shadow_heap[pos] <= shadow_heap[par])
                        break;
                    tmp               = shadow_heap[par];
                    shadow_heap[par]  = shadow_heap[pos];
                    shadow_heap[pos]  = tmp;
                    pos               = par;
                end
            end
        end
        else begin
            if (shadow_fill == 0) begin
                res.status = ST_EMPTY;
            end
            else begin
                res.removed    = shadow_heap[1];
                shadow_heap[1] = shadow_heap[shadow_fill];
                shadow_fill--;
                // sift down toward the larger child, left wins a tie
                pos = 1;
                while (1) begin
                    lch  = 2 * pos;
                    rch  = lch + 1;
                    best = pos;
                    if (lch <= shadow_fill && shadow_heap[lch] > shadow_heap[best])
                        best = lch;
                    if (rch <= shadow_fill && shadow_heap[rch] > shadow_heap[best])
                        best = rch;
                    if (best == pos)
                        break;
                    tmp               = shadow_heap[pos];
                    shadow_heap[pos]  = shadow_heap[best];
                    shadow_heap[best] = tmp;
                    pos               = best;
                end
            end
        end
        res.top   = (shadow_fill > 0) ? shadow_heap[1] : data_t'(0);
        res.count = count_t'(shadow_fill);
        return res;
    endfunction

    // idling phase follows the number of accepted requests
    function automatic int idle_phase();
        return (accepted_reqs / 150) % 4;
    endfunction

    function automatic bit sender_gap();
        case (idle_phase())
            1:       return $urandom_range(99) < 79;
            3:       return $urandom_range(99) < 37;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_phase())
            2:       return $urandom_range(99) < 79;
            3:       return $urandom_range(99) < 37;
            default: return 1'b0;
        endcase
    endfunction

    // values biased toward extremes and small repeats
    function automatic data_t pick_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0:       return data_t'(32'h7FFF_FFFF);
                    1:       return data_t'(32'h8000_0000);
                    2:       return data_t'(0);
                    default: return data_t'(-1);
                endcase
            end
            1, 2:    return data_t'(int'($urandom_range(16)) - 8);
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic add_req(op_t op, data_t value);
        heap_req_t item;
        item.op    = op;
        item.value = value;
        pending_reqs.push_back(item);
        if (op == OP_INSERT && gen_fill < HEAP_DEPTH)
            gen_fill++;
        else if (op == OP_REMOVE && gen_fill > 0)
            gen_fill--;
    endtask

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // request driver, predicts every accepted transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end
        else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(heap_apply(op_t'(req_if.opcode), req_if.value));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && (hold_left != 0 || !sender_gap())) begin
                    next_req       = pending_reqs.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.opcode <= next_req.op;
                    req_if.value  <= next_req.value;
                end
                else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response ready with random stalls
    always @(posedge clk) begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= (hold_left == 0) && !receiver_stall();
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_reqs >= 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // response monitor, compares against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got removed %0d top %0d count %0d status %0d",
                         $time, rsp_if.removed_value, rsp_if.top_value, rsp_if.entry_count,
                         rsp_if.status);
                fail_count++;
            end
            else begin
                due = expected_results.pop_front();
                check_field("removed_value", due.removed, rsp_if.removed_value);
                check_field("top_value", due.top, rsp_if.top_value);
                check_field("entry_count", due.count, rsp_if.entry_count);
                check_field("status", due.status, rsp_if.status);
                checked_results++;
                if (due.status == ST_FULL)
                    full_drops++;
                if (due.status == ST_EMPTY)
                    empty_removes++;
                if (due.count > peak_fill)
                    peak_fill = due.count;
            end
        end
    end

    // stimulus and end of run
    initial begin
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_INSERT;
        req_if.value    = '0;
        rsp_if.ready    = 1'b0;
        rst_n           = 1'b0;
        shadow_fill     = 0;
        gen_fill        = 0;
        accepted_reqs   = 0;
        checked_results = 0;
        fail_count      = 0;
        full_drops      = 0;
        empty_removes   = 0;
        peak_fill       = 0;

        // directed: empty remove, extremes, equal values, drain past empty
        add_req(OP_REMOVE, data_t'(0));
        add_req(OP_INSERT, data_t'(0));
        add_req(OP_INSERT, data_t'(32'h7FFF_FFFF));
        add_req(OP_INSERT, data_t'(32'h8000_0000));
        add_req(OP_INSERT, data_t'(-1));
        add_req(OP_INSERT, data_t'(1));
        add_req(OP_INSERT, data_t'(5));
        add_req(OP_INSERT, data_t'(5));
        add_req(OP_INSERT, data_t'(5));
        repeat (8)
            add_req(OP_REMOVE, data_t'($urandom));
        add_req(OP_REMOVE, data_t'(32'hFFFF_FFFF));

        // random mix around a small heap
        repeat (60)
            add_req(op_t'($urandom_range(1)), pick_value());

        // fill to capacity, then inserts that must be dropped
        while (gen_fill < HEAP_DEPTH)
            add_req(($urandom_range(19) == 0) ? OP_REMOVE : OP_INSERT, pick_value());
        repeat (6)
            add_req(OP_INSERT, pick_value());
        add_req(OP_REMOVE, pick_value());
        add_req(OP_INSERT, pick_value());
        add_req(OP_INSERT, pick_value());

        // deep sift-downs from a full heap, then a final mix
        repeat (30)
            add_req(OP_REMOVE, pick_value());
        repeat (20)
            add_req(op_t'($urandom_range(1)), pick_value());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("checked %0d results over %0d requests, peak fill %0d of %0d",
                 checked_results, accepted_reqs, peak_fill, HEAP_DEPTH);
        $display("inserts dropped at full: %0d, removes on empty: %0d",
                 full_drops, empty_removes);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timeout at %0t with %0d results outstanding", $time, expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
